>>> rtl/bin_to_object_record_framer_core_assert.svh
// Assertion macros used by the framer's command queue (bof_queue).
`ifndef BIN_TO_OBJECT_RECORD_FRAMER_CORE_ASSERT_SVH
`define BIN_TO_OBJECT_RECORD_FRAMER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define BOF_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("bof assertion failed");

`define BOF_ASSERT_NEVER(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("bof forbidden condition");

`else

`define BOF_ASSERT(name, clk, rstn, prop)

`define BOF_ASSERT_NEVER(name, clk, rstn, expr)

`endif

`endif

>>> rtl/bof_pkg.sv
package bof_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int IDX_W = 4;

    localparam logic [7:0]  REC_CONTENT      = 8'h06;
    localparam logic [7:0]  REC_MODEND       = 8'h04;
    localparam logic [7:0]  MODEND_LEN_LO    = 8'h05;
    localparam logic [7:0]  MODEND_TYPE      = 8'h01;
    localparam logic [7:0]  REC_EOF          = 8'h0E;
    localparam logic [7:0]  EOF_LEN_LO       = 8'h01;
    localparam logic [7:0]  EOF_CSUM         = 8'hF1;
    localparam logic [7:0]  ZERO_BYTE        = 8'h00;
    localparam logic [15:0] HDR_OVERHEAD     = 16'd4;
    localparam logic [7:0]  MODEND_FIXED_SUM = 8'd10;

    localparam logic [IDX_W-1:0] HDR_LAST_IDX = IDX_W'(5);
    localparam logic [IDX_W-1:0] END_LAST_IDX = IDX_W'(11);

    typedef enum logic [1:0] {
        CMD_DATA = 2'b00,
        CMD_HDR  = 2'b01,
        CMD_END  = 2'b10
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [15:0] rlen;
        logic [7:0]  csum;
        logic        with_csum;
    } cmd_t;

endpackage

>>> rtl/bof_front.sv
module bof_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_in_byte,
    input  logic          q_full,
    output logic          q_push,
    output bof_pkg::cmd_t q_cmd
);
    import bof_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_DATA   = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hdr_idx_reg, hdr_idx_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  addr_lo_reg, addr_lo_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  sum_reg, sum_next;

    logic        accept;
    logic [15:0] rlen;
    logic [7:0]  data_sum;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign rlen     = len_reg + HDR_OVERHEAD;
    assign data_sum = sum_reg + s_in_byte;

    always_comb begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        len_next     = len_reg;
        addr_lo_next = addr_lo_reg;
        remain_next  = remain_reg;
        sum_next     = sum_reg;
        q_push       = 1'b0;
        q_cmd        = '{kind: CMD_DATA, byte_a: addr_lo_reg, byte_b: s_in_byte,
                         rlen: rlen, csum: 8'h00, with_csum: 1'b0};
        if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    unique case (hdr_idx_reg)
                        2'd0: begin
                            len_next     = {8'h00, s_in_byte};
                            hdr_idx_next = 2'd1;
                        end
                        2'd1: begin
                            len_next     = {s_in_byte, len_reg[7:0]};
                            hdr_idx_next = 2'd2;
                        end
                        2'd2: begin
                            addr_lo_next = s_in_byte;
                            hdr_idx_next = 2'd3;
                        end
                        default: begin
                            hdr_idx_next = 2'd0;
                            q_push       = 1'b1;
                            if (len_reg == 16'h0000) begin
                                q_cmd.kind  = CMD_END;
                                q_cmd.csum  = 8'h00 - (MODEND_FIXED_SUM + addr_lo_reg
                                                       + s_in_byte);
                                sum_next    = 8'h00;
                                phase_next  = PH_DONE;
                            end else begin
                                q_cmd.kind  = CMD_HDR;
                                sum_next    = REC_CONTENT + rlen[7:0] + rlen[15:8]
                                              + addr_lo_reg + s_in_byte;
                                remain_next = len_reg;
                                phase_next  = PH_DATA;
                            end
                        end
                    endcase
                end
                PH_DATA: begin
                    q_push      = 1'b1;
                    remain_next = remain_reg - 16'd1;
                    if (remain_reg == 16'd1) begin
                        q_cmd.csum      = 8'h00 - data_sum;
                        q_cmd.with_csum = 1'b1;
                        sum_next        = 8'h00;
                        phase_next      = PH_HEADER;
                    end else begin
                        sum_next = data_sum;
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= 2'd0;
            len_reg     <= 16'h0000;
            addr_lo_reg <= 8'h00;
            remain_reg  <= 16'h0000;
            sum_reg     <= 8'h00;
        end else begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            len_reg     <= len_next;
            addr_lo_reg <= addr_lo_next;
            remain_reg  <= remain_next;
            sum_reg     <= sum_next;
        end
    end

endmodule

>>> rtl/bof_queue.sv
`include "bin_to_object_record_framer_core_assert.svh"

module bof_queue #(
    parameter int DEPTH = bof_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bof_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output bof_pkg::cmd_t head_cmd,
    output logic          empty
);
    import bof_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BOF_ASSERT(a_no_overflow, aclk, aresetn, push |-> !full)
    `BOF_ASSERT(a_no_underflow, aclk, aresetn, pop |-> !empty)
    `BOF_ASSERT_NEVER(a_count_range, aclk, aresetn, count_reg > CNT_W'(DEPTH))

endmodule

>>> rtl/bof_back.sv
module bof_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  bof_pkg::cmd_t head_cmd,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_run_last,
    output logic          m_module_done
);
    import bof_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             done_reg;

    logic       load;
    logic [7:0] cur_byte;
    logic       cur_last;

    always_comb begin
        cur_byte = ZERO_BYTE;
        cur_last = 1'b0;
        unique case (head_cmd.kind)
            CMD_HDR: begin
                cur_last = (idx_reg == HDR_LAST_IDX);
                unique case (idx_reg)
                    IDX_W'(0): cur_byte = REC_CONTENT;
                    IDX_W'(1): cur_byte = head_cmd.rlen[7:0];
                    IDX_W'(2): cur_byte = head_cmd.rlen[15:8];
                    IDX_W'(3): cur_byte = ZERO_BYTE;
                    IDX_W'(4): cur_byte = head_cmd.byte_a;
                    default:   cur_byte = head_cmd.byte_b;
                endcase
            end
            CMD_END: begin
                cur_last = (idx_reg == END_LAST_IDX);
                unique case (idx_reg)
                    IDX_W'(0):  cur_byte = REC_MODEND;
                    IDX_W'(1):  cur_byte = MODEND_LEN_LO;
                    IDX_W'(2):  cur_byte = ZERO_BYTE;
                    IDX_W'(3):  cur_byte = MODEND_TYPE;
                    IDX_W'(4):  cur_byte = ZERO_BYTE;
                    IDX_W'(5):  cur_byte = head_cmd.byte_a;
                    IDX_W'(6):  cur_byte = head_cmd.byte_b;
                    IDX_W'(7):  cur_byte = head_cmd.csum;
                    IDX_W'(8):  cur_byte = REC_EOF;
                    IDX_W'(9):  cur_byte = EOF_LEN_LO;
                    IDX_W'(10): cur_byte = ZERO_BYTE;
                    default:    cur_byte = EOF_CSUM;
                endcase
            end
            default: begin
                cur_last = !head_cmd.with_csum || idx_reg[0];
                cur_byte = idx_reg[0] ? head_cmd.csum : head_cmd.byte_b;
            end
        endcase
    end

    assign load       = !q_empty && (!valid_reg || m_ready);
    assign q_pop      = load && cur_last;
    assign valid_next = load || (valid_reg && !m_ready);

    always_comb begin
        priority if (q_pop) begin
            idx_next = '0;
        end else if (load) begin
            idx_next = idx_reg + 1'b1;
        end else begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= cur_byte;
            last_reg <= cur_last;
            done_reg <= (head_cmd.kind == CMD_END);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_run_last    = last_reg;
    assign m_module_done = done_reg;

endmodule

>>> rtl/bin_to_object_record_framer_core.sv
// Object record framer: takes one stream byte per cycle while the command
// queue (QUEUE_DEPTH entries) has room, and sends one record byte per cycle
// while m_ready is high and a command is queued. A data byte yields one output
// byte (two on the last byte of a block); the fourth header byte yields six
// bytes (content record header) or twelve (module end and end-of-file records),
// so input stalls after such a header once the queue fills. Commands are
// registered in the queue, bytes in the output register. After the zero-length
// header every later byte is taken and dropped.
module bin_to_object_record_framer_core #(
    parameter int QUEUE_DEPTH = bof_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_module_done
);
    import bof_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    bof_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    bof_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    bof_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_cmd      (head_cmd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_module_done (m_module_done)
    );

endmodule
